FILE: rtl/top_k_score_table_insert_macros.svh
// Assertion macros shared by the score table RTL.
`ifndef TOP_K_SCORE_TABLE_INSERT_MACROS_SVH
`define TOP_K_SCORE_TABLE_INSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TKST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TKST_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tkst_pkg.sv
// Types, constants and helper functions for the top-k score table.
package tkst_pkg;

  // Table geometry
  localparam int TABLE_DEPTH  = 1024;
  localparam int MAX_SET_SIZE = 6;
  localparam int LOCUS_BITS   = 16;

  // Fixed field widths of the stream words
  localparam int NUM_LOCI      = 6;
  localparam int FIELD_LOCUS_W = 16;
  localparam int SCORE_W       = 32;
  localparam int SLOT_W        = 10;
  localparam int SET_W         = 3;

  // Cell index and reduction grouping
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int GROUP_SIZE   = 32;
  localparam int NUM_GROUPS   = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PADDED_DEPTH = NUM_GROUPS * GROUP_SIZE;

  // Stream word layout
  localparam int IN_LOCUS_LSB = SCORE_W;
  localparam int IN_SLOT_LSB  = SCORE_W + NUM_LOCI * FIELD_LOCUS_W;
  localparam int IN_FIELDS_W  = IN_SLOT_LSB + SLOT_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SLOT_W + SCORE_W + NUM_LOCI * FIELD_LOCUS_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Register map
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_LOCI_IN_USE = 3'd0;
  localparam logic [SET_W-1:0]      LOCI_RESET      = 3'd6;

  typedef logic [NUM_LOCI-1:0][FIELD_LOCUS_W-1:0] field_loci_t;
  typedef logic [MAX_SET_SIZE-1:0][LOCUS_BITS-1:0] set_t;

  // One table entry
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    set_t               loci;
  } entry_t;

  // Per-cell compare results
  typedef struct packed {
    logic less;  // offer score above this cell's score
    logic eq;    // offer score equals this cell's score
    logic hit;   // this cell is the one being read
  } cell_flag_t;

  // Reduced result of one group of cells
  typedef struct packed {
    logic             any_eq;
    logic             edge_found;
    logic [IDX_W-1:0] edge_idx;
    entry_t           rd;
  } group_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_GRP,
    ST_MERGE,
    ST_COMMIT
  } state_t;

  // Locus count as used: 0 counts as 1, large values clamp
  function automatic logic [SET_W-1:0] active_loci(logic [SET_W-1:0] v);
    if (v == '0) return SET_W'(1);
    else if (v > SET_W'(MAX_SET_SIZE)) return SET_W'(MAX_SET_SIZE);
    else return v;
  endfunction

  // Keep the first n loci of an offer, zero the rest
  function automatic set_t mask_loci(field_loci_t loci, logic [SET_W-1:0] n);
    set_t res;
    res = '0;
    for (int j = 0; j < MAX_SET_SIZE; j++) begin
      if (SET_W'(j) < n) res[j] = LOCUS_BITS'(loci[j]);
    end
    return res;
  endfunction

  // Stored loci to 16-bit report fields; missing loci read as zero
  function automatic field_loci_t report_loci(set_t loci);
    field_loci_t res;
    res = '0;
    for (int j = 0; j < MAX_SET_SIZE; j++) begin
      res[j] = FIELD_LOCUS_W'(loci[j]);
    end
    return res;
  endfunction

endpackage

FILE: rtl/top_k_score_table_insert.sv
// Top level: sorted top-k score table built as a chain of cells.
// Keeps TABLE_DEPTH scored locus sets sorted by ascending score, slot 0 smallest.
// Input words (s_t*): s_tuser selects offer (0) or read (1). An offer above
// slot 0 whose score matches no stored score is inserted: slot 0 drops out,
// lower entries shift down one cell and the offer lands at its sorted slot.
// Every input word yields exactly one output word on m_t*.
// One word is in work at a time: the next is taken only after the result is
// registered. Each word passes through compare in all cells, a registered
// group reduction, a registered merge, then the shift/commit.
// Reset clears every cell to score zero and loci zero and sets
// loci_in_use to 6. A stalled receiver holds the result in the output
// register; a following word is still taken and worked up to commit, where it
// waits (cells unchanged) until the output register is free.
// Configuration (APB, register 0 = loci_in_use) must be written only while idle; the block itself does not enforce it.
`include "top_k_score_table_insert_macros.svh"

module top_k_score_table_insert (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input word stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // score[31:0], locus_a..locus_f[127:32], read_slot[137:128], zero pad
  input  logic [tkst_pkg::IN_DATA_W-1:0]        s_tdata,
  // operation[0]
  input  logic [0:0]                            s_tuser,
  // Output word stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // slot[9:0], slot_score[41:10], slot_locus_a..slot_locus_f[137:42], zero pad
  output logic [tkst_pkg::OUT_DATA_W-1:0]       m_tdata,
  // accepted[0], duplicate[1]
  output logic [1:0]                            m_tuser,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tkst_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import tkst_pkg::*;

  state_t                          state, state_next;
  logic [SET_W-1:0]                loci_in_use;
  logic                            op_read;
  entry_t                          offer;
  logic [SLOT_W-1:0]               rd_slot;
  field_loci_t                     in_loci;
  logic                            cmp_en, grp_en, mrg_en, out_load, shift_en;
  cell_flag_t [PADDED_DEPTH-1:0]   flags_all;
  entry_t [PADDED_DEPTH-1:0]       ents_all;
  group_res_t [NUM_GROUPS-1:0]     grp_res;
  group_res_t                      mrg_next, mrg;
  logic                            mrg_less0, mrg_take;
  logic                            res_acc, res_dup;
  logic [SLOT_W-1:0]               res_slot;
  logic [SCORE_W-1:0]              res_score;
  field_loci_t                     res_loci;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_LOCI_IN_USE) ? 32'(loci_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      loci_in_use <= LOCI_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_LOCI_IN_USE) begin
      loci_in_use <= pwdata[SET_W-1:0];
    end
  end

  // Capture the input word
  assign in_loci = s_tdata[IN_LOCUS_LSB +: NUM_LOCI*FIELD_LOCUS_W];

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_read     <= s_tuser[0];
      offer.score <= s_tdata[SCORE_W-1:0];
      offer.loci  <= mask_loci(in_loci, active_loci(loci_in_use));
      rd_slot     <= s_tdata[IN_SLOT_LSB +: SLOT_W];
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE:   state_next = s_tvalid ? ST_CMP : ST_IDLE;
      ST_CMP:    state_next = ST_GRP;
      ST_GRP:    state_next = ST_MERGE;
      ST_MERGE:  state_next = ST_COMMIT;
      ST_COMMIT: state_next = (!m_tvalid || m_tready) ? ST_IDLE : ST_COMMIT;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = state == ST_IDLE;
    cmp_en   = state == ST_CMP;
    grp_en   = state == ST_GRP;
    mrg_en   = state == ST_MERGE;
    out_load = state == ST_COMMIT && (!m_tvalid || m_tready);
    shift_en = out_load && !op_read && mrg_take;
  end

  // Chain of cells; padding positions read as empty
  for (genvar i = 0; i < PADDED_DEPTH; i++) begin : g_cell
    if (i < TABLE_DEPTH) begin : g_real
      entry_t nb_ent;
      logic   nb_less;
      if (i + 1 < TABLE_DEPTH) begin : g_nb
        assign nb_ent  = ents_all[i+1];
        assign nb_less = flags_all[i+1].less;
      end else begin : g_top
        assign nb_ent  = '0;
        assign nb_less = 1'b0;
      end
      tkst_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cmp_en   (cmp_en),
        .shift_en (shift_en),
        .offer    (offer),
        .rd_hit   (op_read && (32'(rd_slot) == 32'(i))),
        .nb_ent   (nb_ent),
        .nb_less  (nb_less),
        .ent      (ents_all[i]),
        .flags    (flags_all[i])
      );
    end else begin : g_pad
      assign ents_all[i]  = '0;
      assign flags_all[i] = '0;
    end
  end

  // First reduction level
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    logic next_less;
    if (g + 1 < NUM_GROUPS) begin : g_nx
      assign next_less = flags_all[(g+1)*GROUP_SIZE].less;
    end else begin : g_last
      assign next_less = 1'b0;
    end
    tkst_group u_group (
      .clk         (clk),
      .grp_en      (grp_en),
      .flags       (flags_all[g*GROUP_SIZE +: GROUP_SIZE]),
      .ents        (ents_all[g*GROUP_SIZE +: GROUP_SIZE]),
      .next_less   (next_less),
      .first_index (IDX_W'(g*GROUP_SIZE)),
      .res         (grp_res[g])
    );
  end

  // Second reduction level across groups
  always_comb begin
    mrg_next = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      mrg_next.any_eq     = mrg_next.any_eq | grp_res[g].any_eq;
      mrg_next.edge_found = mrg_next.edge_found | grp_res[g].edge_found;
      if (grp_res[g].edge_found) begin
        mrg_next.edge_idx = mrg_next.edge_idx | grp_res[g].edge_idx;
      end
      mrg_next.rd = mrg_next.rd | grp_res[g].rd;
    end
  end

  always_ff @(posedge clk) begin
    if (mrg_en) begin
      mrg       <= mrg_next;
      mrg_less0 <= flags_all[0].less;
      mrg_take  <= flags_all[0].less && !mrg_next.any_eq;
    end
  end

  // Result word
  always_comb begin
    res_acc   = 1'b0;
    res_dup   = 1'b0;
    res_slot  = '0;
    res_score = '0;
    res_loci  = '0;
    priority if (op_read) begin
      res_slot  = rd_slot;
      res_score = mrg.rd.score;
      res_loci  = report_loci(mrg.rd.loci);
    end else if (mrg_take) begin
      res_acc   = 1'b1;
      res_slot  = SLOT_W'(mrg.edge_idx);
      res_score = offer.score;
      res_loci  = report_loci(offer.loci);
    end else begin
      res_dup = mrg_less0 && mrg.any_eq;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, res_loci, res_score, res_slot};
      m_tuser <= {res_dup, res_acc};
    end
  end

  // Checks
  `TKST_ASSERT_IMP(a_flags_exclusive, clk, rst, m_tvalid, !(m_tuser[0] && m_tuser[1]), "accepted and duplicate both set")
  `TKST_ASSERT_NXT(a_one_in_work, clk, rst, s_tvalid && s_tready, !s_tready, "second word taken while one is in work")
  `TKST_ASSERT_IMP(a_insert_has_edge, clk, rst, shift_en, mrg.edge_found, "insert committed without a landing slot")

endmodule

FILE: rtl/tkst_cell.sv
// One table cell: holds an entry, compares it and shifts from its upper neighbour.
module tkst_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmp_en,
  input  logic                shift_en,
  input  tkst_pkg::entry_t    offer,
  input  logic                rd_hit,
  input  tkst_pkg::entry_t    nb_ent,
  input  logic                nb_less,
  output tkst_pkg::entry_t    ent,
  output tkst_pkg::cell_flag_t flags
);
  import tkst_pkg::*;

  // Compare flags, held until the insert is committed
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      flags.less <= offer.score > ent.score;
      flags.eq   <= offer.score == ent.score;
      flags.hit  <= rd_hit;
    end
  end

  // Entry: take the neighbour's entry below the landing cell, the offer at it
  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else if (shift_en) begin
      if (nb_less) begin
        ent <= nb_ent;
      end else if (flags.less) begin
        ent <= offer;
      end
    end
  end

endmodule

FILE: rtl/tkst_group.sv
// First reduction level over one group of cells: duplicate, landing edge, read data.
module tkst_group (
  input  logic                                                  clk,
  input  logic                                                  grp_en,
  input  tkst_pkg::cell_flag_t [tkst_pkg::GROUP_SIZE-1:0]       flags,
  input  tkst_pkg::entry_t [tkst_pkg::GROUP_SIZE-1:0]           ents,
  input  logic                                                  next_less,
  input  logic [tkst_pkg::IDX_W-1:0]                            first_index,
  output tkst_pkg::group_res_t                                  res
);
  import tkst_pkg::*;

  logic [GROUP_SIZE:0] less_vec;
  group_res_t          res_next;

  // Less flags of this group plus the first cell of the next group
  always_comb begin
    for (int j = 0; j < GROUP_SIZE; j++) begin
      less_vec[j] = flags[j].less;
    end
    less_vec[GROUP_SIZE] = next_less;
  end

  // OR reduction; the landing edge is the last cell whose flag is set
  always_comb begin
    res_next = '0;
    for (int j = 0; j < GROUP_SIZE; j++) begin
      res_next.any_eq = res_next.any_eq | flags[j].eq;
      if (flags[j].hit) begin
        res_next.rd = res_next.rd | ents[j];
      end
      if (less_vec[j] && !less_vec[j+1]) begin
        res_next.edge_found = 1'b1;
        res_next.edge_idx   = res_next.edge_idx | (first_index + IDX_W'(j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_en) begin
      res <= res_next;
    end
  end

endmodule
